// ===== rtl/h2d_pkg.sv =====
`default_nettype none

package h2d_pkg;

  // Largest frame the line store is sized for.
  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;

  // Line store: one entry per top-row pixel pair.
  localparam int StoreDepth = MaxWidth / 2;
  localparam int StoreAw    = $clog2(StoreDepth);

  // Field widths.
  localparam int PixW   = 8;
  localparam int PairW  = 2 * PixW;
  localparam int CfgW   = 12;
  localparam int CoefW  = 10;
  localparam int BlkW   = 10;
  localparam int ColCntW = $clog2(MaxWidth);
  localparam int RowCntW = $clog2(MaxHeight);
  localparam int CfgIdxW = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgIdxWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxHeight = 2'd1;

  // Register reset values and clamp limits.
  localparam logic [CfgW-1:0] WidthReset  = 12'd640;
  localparam logic [CfgW-1:0] HeightReset = 12'd480;
  localparam logic [CfgW-1:0] SizeMin     = 12'd2;
  localparam logic [CfgW-1:0] WidthMax    = CfgW'(MaxWidth);
  localparam logic [CfgW-1:0] HeightMax   = CfgW'(MaxHeight);

  // Line store access issued for one accepted pixel.
  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [StoreAw-1:0] addr;
    logic [PairW-1:0]   wr_data;
  } ram_req_t;

  // Bottom-row half of a block plus its position, handed to the datapath.
  typedef struct packed {
    logic [PixW-1:0] c;
    logic [PixW-1:0] d;
    logic [BlkW-1:0] bcol;
    logic [BlkW-1:0] brow;
    logic            last;
  } blk_t;

endpackage

`default_nettype wire

// ===== rtl/h2d_line_ram.sv =====
`default_nettype none

module h2d_line_ram (
  input  wire logic                          clk_i,
  input  wire h2d_pkg::ram_req_t             req_i,
  output logic [h2d_pkg::PairW-1:0]          rd_data_o
);

  logic [h2d_pkg::PairW-1:0] mem_q [h2d_pkg::StoreDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/h2d_ctrl.sv =====
`default_nettype none

module h2d_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [h2d_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [h2d_pkg::CfgW-1:0]      cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire logic [h2d_pkg::PixW-1:0]      pixel_i,
  output h2d_pkg::ram_req_t                  ram_req_o,
  output logic                               issue_o,
  output h2d_pkg::blk_t                      blk_o
);

  logic [h2d_pkg::CfgW-1:0]    width_q, height_q;
  logic [h2d_pkg::CfgW-1:0]    w_eff, h_eff, w_even, h_even;
  logic [h2d_pkg::ColCntW-1:0] col_q, col_d;
  logic [h2d_pkg::RowCntW-1:0] row_q, row_d;
  logic [h2d_pkg::PixW-1:0]    left_q;
  logic [h2d_pkg::CfgW-1:0]    col_inc, row_inc;
  logic [h2d_pkg::BlkW-1:0]    bcol, brow, last_col, last_row;
  logic                        accept, pair_ok, row_ok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= h2d_pkg::WidthReset;
      height_q <= h2d_pkg::HeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        h2d_pkg::CfgIdxWidth:  width_q  <= cfg_data_i;
        h2d_pkg::CfgIdxHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the sizes into the supported range.
  always_comb begin
    if (width_q < h2d_pkg::SizeMin) begin
      w_eff = h2d_pkg::SizeMin;
    end else if (width_q > h2d_pkg::WidthMax) begin
      w_eff = h2d_pkg::WidthMax;
    end else begin
      w_eff = width_q;
    end
    if (height_q < h2d_pkg::SizeMin) begin
      h_eff = h2d_pkg::SizeMin;
    end else if (height_q > h2d_pkg::HeightMax) begin
      h_eff = h2d_pkg::HeightMax;
    end else begin
      h_eff = height_q;
    end
  end

  assign w_even   = {w_eff[h2d_pkg::CfgW-1:1], 1'b0};
  assign h_even   = {h_eff[h2d_pkg::CfgW-1:1], 1'b0};
  assign last_col = h2d_pkg::BlkW'((w_eff >> 1) - 1'b1);
  assign last_row = h2d_pkg::BlkW'((h_eff >> 1) - 1'b1);

  assign accept = in_valid_i && in_ready_i;
  assign bcol   = col_q[h2d_pkg::ColCntW-1:1];
  assign brow   = row_q[h2d_pkg::RowCntW-1:1];

  // A right-hand pixel inside the even part of the row closes a pair.
  assign pair_ok = col_q[0] && (h2d_pkg::CfgW'(col_q) < w_even);
  assign row_ok  = h2d_pkg::CfgW'(row_q) < h_even;

  always_comb begin
    ram_req_o.rd_en   = accept && pair_ok && row_q[0] && row_ok;
    ram_req_o.wr_en   = accept && pair_ok && !row_q[0];
    ram_req_o.addr    = bcol;
    ram_req_o.wr_data = {left_q, pixel_i};
  end

  assign issue_o = ram_req_o.rd_en;

  always_comb begin
    blk_o.c    = left_q;
    blk_o.d    = pixel_i;
    blk_o.bcol = bcol;
    blk_o.brow = brow;
    blk_o.last = (bcol == last_col) && (brow == last_row);
  end

  // Raster position; counters left beyond the size by a register change wrap.
  always_comb begin
    col_inc = h2d_pkg::CfgW'(col_q) + 1'b1;
    row_inc = h2d_pkg::CfgW'(row_q) + 1'b1;
    col_d   = h2d_pkg::ColCntW'(col_inc);
    row_d   = row_q;
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : h2d_pkg::RowCntW'(row_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      if (!col_q[0]) begin
        left_q <= pixel_i;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req_o.rd_en && ram_req_o.wr_en))
    else $error("line store read and write issued for the same pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req_o.rd_en || ram_req_o.wr_en) |-> (in_valid_i && in_ready_i))
    else $error("line store accessed without an accepted pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !col_q[0]) |-> !(ram_req_o.rd_en || ram_req_o.wr_en))
    else $error("line store accessed on a left-hand pixel");

endmodule

`default_nettype wire

// ===== rtl/h2d_calc.sv =====
`default_nettype none

module h2d_calc (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          issue_i,
  input  wire h2d_pkg::blk_t                 blk_i,
  input  wire logic [h2d_pkg::PairW-1:0]     rd_data_i,
  output logic                               in_ready_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [h2d_pkg::CoefW-1:0]          ll_o,
  output logic signed [h2d_pkg::CoefW-1:0]   lh_o,
  output logic signed [h2d_pkg::CoefW-1:0]   hl_o,
  output logic signed [h2d_pkg::CoefW-1:0]   hh_o,
  output logic [h2d_pkg::BlkW-1:0]           block_col_o,
  output logic [h2d_pkg::BlkW-1:0]           block_row_o,
  output logic                               last_block_o
);

  logic                       s1_valid_q, s1_go;
  h2d_pkg::blk_t              s1_blk_q;
  logic [h2d_pkg::CoefW-1:0]  a, b, c, d, ab_sum, ab_dif, cd_sum, cd_dif;

  // Stage 1 waits for the line store read; it moves on when the output is free.
  assign s1_go      = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (issue_i) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      s1_blk_q <= blk_i;
    end
  end

  assign a      = h2d_pkg::CoefW'(rd_data_i[h2d_pkg::PairW-1:h2d_pkg::PixW]);
  assign b      = h2d_pkg::CoefW'(rd_data_i[h2d_pkg::PixW-1:0]);
  assign c      = h2d_pkg::CoefW'(s1_blk_q.c);
  assign d      = h2d_pkg::CoefW'(s1_blk_q.d);
  assign ab_sum = a + b;
  assign ab_dif = a - b;
  assign cd_sum = c + d;
  assign cd_dif = c - d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_go) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      ll_o         <= ab_sum + cd_sum;
      lh_o         <= $signed(ab_sum - cd_sum);
      hl_o         <= $signed(ab_dif + cd_dif);
      hh_o         <= $signed(ab_dif - cd_dif);
      block_col_o  <= s1_blk_q.bcol;
      block_row_o  <= s1_blk_q.brow;
      last_block_o <= s1_blk_q.last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_o && !out_ready_i) |=> s1_valid_q)
    else $error("pending block dropped while the output stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((ll_o[0] == lh_o[0]) && (ll_o[0] == hl_o[0]) && (ll_o[0] == hh_o[0])))
    else $error("Haar coefficients disagree in parity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(ll_o) && $stable(block_col_o)))
    else $error("output request changed while it waited");

endmodule

`default_nettype wire

// ===== rtl/haar2d_forward_stream_top.sv =====
// A block's bottom pair and its stored top pair are registered when its bottom-right pixel
// is accepted; its coefficients then move into the output register once that is free.
// Throughput: one pixel per cycle, since each pixel makes at most one line store access.
// The input stalls only while a block waits behind an output request that is not taken.
// Reset: counters and the left pixel clear, sizes return to 640 by 480, the store is not cleared.
// Store entries are written in a top row before the row below reads them, unless the width grows between.
`default_nettype none

module haar2d_forward_stream_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write channel.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [h2d_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [h2d_pkg::CfgW-1:0]      cfg_data_i,
  // Pixel request channel.
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [h2d_pkg::PixW-1:0]      pixel_i,
  // Coefficient request channel.
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [h2d_pkg::CoefW-1:0]          ll_o,
  output logic signed [h2d_pkg::CoefW-1:0]   lh_o,
  output logic signed [h2d_pkg::CoefW-1:0]   hl_o,
  output logic signed [h2d_pkg::CoefW-1:0]   hh_o,
  output logic [h2d_pkg::BlkW-1:0]           block_col_o,
  output logic [h2d_pkg::BlkW-1:0]           block_row_o,
  output logic                               last_block_o
);

  // The control unit tracks the raster position. A right-hand pixel on an even
  // row writes the top pair into the line store; on an odd row it reads the
  // pair back and hands the bottom pair to the datapath as a pending block.
  h2d_pkg::ram_req_t         ram_req;
  h2d_pkg::blk_t             blk;
  logic                      issue;
  logic [h2d_pkg::PairW-1:0] rd_data;

  h2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .pixel_i     (pixel_i),
    .ram_req_o   (ram_req),
    .issue_o     (issue),
    .blk_o       (blk)
  );

  // The line store holds one top-row pair per block column and registers
  // its read data.
  h2d_line_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  // The datapath combines the stored pair with the bottom pair and keeps the
  // result in an output register, so new pixels are taken while it waits until the next block is pending.
  h2d_calc u_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (issue),
    .blk_i        (blk),
    .rd_data_i    (rd_data),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ll_o         (ll_o),
    .lh_o         (lh_o),
    .hl_o         (hl_o),
    .hh_o         (hh_o),
    .block_col_o  (block_col_o),
    .block_row_o  (block_row_o),
    .last_block_o (last_block_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_haar2d_forward_stream_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_haar2d_forward_stream_top;

  localparam int ClkHalfNs     = 6;
  localparam int RstCycles     = 12;
  localparam int CycleLimit    = 600000;
  localparam int SettleCycles  = 8;
  localparam int RxHoldCycles  = 300;
  localparam int RandomPixels  = 400;
  localparam int MaxReports    = 10;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [h2d_pkg::CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  // One coefficient block as it leaves the block.
  typedef struct packed {
    logic [h2d_pkg::CoefW-1:0] ll;
    logic [h2d_pkg::CoefW-1:0] lh;
    logic [h2d_pkg::CoefW-1:0] hl;
    logic [h2d_pkg::CoefW-1:0] hh;
    logic [h2d_pkg::BlkW-1:0]  bcol;
    logic [h2d_pkg::BlkW-1:0]  brow;
    logic                      last;
  } haar_block_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [h2d_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [h2d_pkg::CfgW-1:0]    cfg_data_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [h2d_pkg::PixW-1:0]    pixel_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [h2d_pkg::CoefW-1:0]   ll_o;
  logic [h2d_pkg::CoefW-1:0]   lh_o;
  logic [h2d_pkg::CoefW-1:0]   hl_o;
  logic [h2d_pkg::CoefW-1:0]   hh_o;
  logic [h2d_pkg::BlkW-1:0]    block_col_o;
  logic [h2d_pkg::BlkW-1:0]    block_row_o;
  logic                        last_block_o;

  haar2d_forward_stream_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_i      (pixel_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ll_o         (ll_o),
    .lh_o         (lh_o),
    .hl_o         (hl_o),
    .hh_o         (hh_o),
    .block_col_o  (block_col_o),
    .block_row_o  (block_row_o),
    .last_block_o (last_block_o)
  );

  always #(ClkHalfNs) clk_i = ~clk_i;

  // Mirror of the block state, advanced on every accepted pixel request.
  logic [h2d_pkg::PairW-1:0] pair_store [h2d_pkg::StoreDepth];
  logic [h2d_pkg::PixW-1:0]  left_pix;
  int                        col_cnt;
  int                        row_cnt;
  logic [h2d_pkg::CfgW-1:0]  cfg_width;
  logic [h2d_pkg::CfgW-1:0]  cfg_height;

  haar_block_t pending_blocks[$];

  // Idling knobs read by the sender task and the receiver process.
  bit tx_gaps_on;
  bit rx_stalls_on;
  int rx_hold_reqs;

  int n_cycles;
  int n_pixels;
  int n_writes;
  int n_blocks;
  int n_frame_ends;
  int n_mismatch;
  int n_unexpected;
  int n_reported;

  function automatic int clamp_dim(input logic [h2d_pkg::CfgW-1:0] v, input int hi);
    if (v < h2d_pkg::SizeMin) return int'(h2d_pkg::SizeMin);
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int eff_width();
    return clamp_dim(cfg_width, h2d_pkg::MaxWidth);
  endfunction

  function automatic int eff_height();
    return clamp_dim(cfg_height, h2d_pkg::MaxHeight);
  endfunction

  // Mostly no gap, some short ones and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Full-scale values are favored so the coefficient extremes come up often.
  function automatic logic [h2d_pkg::PixW-1:0] rand_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return h2d_pkg::PixW'($urandom_range(0, 255));
  endfunction

  // Advances the mirrored state by one pixel and queues the block it completes.
  task automatic haar_predict(input logic [h2d_pkg::PixW-1:0] pix);
    int w, h, bcol, brow, a, b, c, d;
    haar_block_t blk;
    w = eff_width();
    h = eff_height();
    bcol = col_cnt >> 1;
    brow = row_cnt >> 1;
    if (col_cnt % 2 == 0) begin
      left_pix = pix;
    end else if (col_cnt < (w & ~1) && bcol < h2d_pkg::StoreDepth) begin
      if (row_cnt % 2 == 0) begin
        pair_store[bcol] = {left_pix, pix};
      end else if (row_cnt < (h & ~1)) begin
        a = int'(pair_store[bcol][h2d_pkg::PairW-1:h2d_pkg::PixW]);
        b = int'(pair_store[bcol][h2d_pkg::PixW-1:0]);
        c = int'(left_pix);
        d = int'(pix);
        blk.ll   = h2d_pkg::CoefW'(a + b + c + d);
        blk.lh   = h2d_pkg::CoefW'(a + b - c - d);
        blk.hl   = h2d_pkg::CoefW'(a - b + c - d);
        blk.hh   = h2d_pkg::CoefW'(a - b - c + d);
        blk.bcol = h2d_pkg::BlkW'(bcol);
        blk.brow = h2d_pkg::BlkW'(brow);
        blk.last = (bcol == w / 2 - 1) && (brow == h / 2 - 1);
        pending_blocks.insert(pending_blocks.size(), blk);
      end
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  // Offers one pixel request, holding it until the block takes it.
  task automatic push_pixel(input logic [h2d_pkg::PixW-1:0] pix);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    haar_predict(pix);
    n_pixels++;
  endtask

  task automatic send_random(input int count);
    repeat (count) push_pixel(rand_pixel());
  endtask

  // Sends the low count bytes of a packed list, first pixel in the highest of them.
  task automatic send_bytes(input logic [191:0] data, input int count);
    for (int i = 0; i < count; i++) push_pixel(data[(count - 1 - i) * 8 +: 8]);
  endtask

  // Sender goes quiet until every expected block is back and the pipe is empty.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [h2d_pkg::CfgIdxW-1:0] idx,
                           input logic [h2d_pkg::CfgW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == h2d_pkg::CfgIdxWidth) cfg_width = val;
    else if (idx == h2d_pkg::CfgIdxHeight) cfg_height = val;
    n_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(h2d_pkg::CfgIdxWidth, h2d_pkg::CfgW'(w));
    write_reg(h2d_pkg::CfgIdxHeight, h2d_pkg::CfgW'(h));
  endtask

  // A 6x4 frame whose six blocks hit the positive and negative extremes of
  // the three detail coefficients.
  task automatic test_directed_extremes();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    wait_drained();
    set_size(6, 4);
    send_bytes({48'h00FFFFFF0000, 48'hFF000000FFFF,
                48'hFF0000FFFF00, 48'hFF0000FF00FF}, 24);
  endtask

  // Odd width and height: the trailing column and the trailing row give no
  // block. The first block also carries the largest low-low value.
  task automatic test_odd_sizes();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    wait_drained();
    set_size(5, 3);
    send_bytes({40'hFFFFFFFF11, 40'hFFFF0000C8, 40'h0908070605}, 15);
    send_random(15);
  endtask

  // Register values outside the legal range are clamped. The oversized
  // frames are cut short by shrinking a size, so the counters wrap early.
  task automatic test_clamped_sizes();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    wait_drained();
    set_size(4095, 1);
    send_random(40);
    wait_drained();
    write_reg(h2d_pkg::CfgIdxWidth, 12'd6);
    send_random(1 + 6);
    wait_drained();
    set_size(0, 4095);
    send_random(12);
    wait_drained();
    write_reg(h2d_pkg::CfgIdxHeight, 12'd2);
    send_random(2);
    wait_drained();
    set_size(1, 0);
    send_random(4);
    wait_drained();
    write_reg(CfgIdxSpare, 12'hFFF);
    write_reg(CfgIdxSpare, 12'h000);
    send_random(8);
  endtask

  // Sizes shrink while the counters sit beyond the new size: the column
  // counter wraps on the next pixel, and a row past the even height is dropped.
  task automatic test_midframe_resize();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    wait_drained();
    set_size(8, 4);
    send_random(22);
    wait_drained();
    write_reg(h2d_pkg::CfgIdxWidth, 12'd4);
    send_random(5);
    wait_drained();
    set_size(4, 4);
    send_random(12);
    wait_drained();
    write_reg(h2d_pkg::CfgIdxHeight, 12'd2);
    send_random(4 + 8);
  endtask

  // The receiver holds off for a long stretch while pixels keep coming, so the
  // block fills and stalls its input; then the sender waits for a full drain.
  task automatic test_backpressure();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    wait_drained();
    set_size(16, 4);
    rx_hold_reqs++;
    send_random(16 * 4);
    wait_drained();
    rx_stalls_on = 1'b1;
    send_random(16 * 4);
  endtask

  // Mostly whole frames of random small sizes. Some runs spill into the next
  // frame, and sizes only change once the counters are back at the frame start.
  task automatic test_random_frames();
    int stop_at, w, h, frame_px, remaining, cnt;
    stop_at = n_pixels + RandomPixels;
    while (n_pixels < stop_at) begin
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      if (col_cnt == 0 && row_cnt == 0 && $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 19))
          0: w = $urandom_range(0, 1);
          1: w = $urandom_range(18, 40);
          default: w = $urandom_range(2, 17);
        endcase
        h = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
        wait_drained();
        set_size(w, h);
      end
      frame_px  = eff_width() * eff_height();
      remaining = frame_px - (row_cnt * eff_width() + col_cnt);
      cnt = ($urandom_range(0, 5) == 0) ? remaining + $urandom_range(1, frame_px) : remaining;
      send_random(cnt);
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  // Receiver side: random stalls, plus a long hold whenever one is requested.
  initial begin : rx_side
    int stall, holds_done;
    stall = 0;
    holds_done = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done != rx_hold_reqs) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (RxHoldCycles) @(negedge clk_i);
      end else if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        stall = rx_stalls_on ? pick_gap() : 0;
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          stall--;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Every accepted coefficient request is matched against the oldest expectation.
  always @(posedge clk_i) begin : block_check
    haar_block_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.ll   = ll_o;
      got.lh   = lh_o;
      got.hl   = hl_o;
      got.hh   = hh_o;
      got.bcol = block_col_o;
      got.brow = block_row_o;
      got.last = last_block_o;
      n_blocks++;
      if (got.last === 1'b1) n_frame_ends++;
      if (pending_blocks.size() == 0) begin
        n_unexpected++;
        if (n_reported < MaxReports) begin
          n_reported++;
          $display("Unexpected block at col %0d row %0d", got.bcol, got.brow);
        end
      end else begin
        want = pending_blocks.pop_front();
        if (got.ll !== want.ll || got.lh !== want.lh || got.hl !== want.hl ||
            got.hh !== want.hh || got.bcol !== want.bcol || got.brow !== want.brow ||
            got.last !== want.last) begin
          n_mismatch++;
          if (n_reported < MaxReports) begin
            n_reported++;
            $display("Block mismatch, expected ll=%0d lh=%0d hl=%0d hh=%0d col=%0d row=%0d last=%0b",
                     want.ll, $signed(want.lh), $signed(want.hl), $signed(want.hh),
                     want.bcol, want.brow, want.last);
            $display("                got      ll=%0d lh=%0d hl=%0d hh=%0d col=%0d row=%0d last=%0b",
                     got.ll, $signed(got.lh), $signed(got.hl), $signed(got.hh),
                     got.bcol, got.brow, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d blocks outstanding",
               n_cycles, pending_blocks.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = h2d_pkg::CfgIdxWidth;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    pixel_i      = '0;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    rx_hold_reqs = 0;
    left_pix     = '0;
    col_cnt      = 0;
    row_cnt      = 0;
    cfg_width    = h2d_pkg::WidthReset;
    cfg_height   = h2d_pkg::HeightReset;
    repeat (RstCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_extremes();
    test_odd_sizes();
    test_clamped_sizes();
    test_midframe_resize();
    test_backpressure();
    test_random_frames();

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d pixels and %0d register writes; checked %0d blocks, %0d frame ends.",
             n_pixels, n_writes, n_blocks, n_frame_ends);
    $display("Mismatches %0d, unexpected blocks %0d, blocks never seen %0d.",
             n_mismatch, n_unexpected, pending_blocks.size());
    if (n_mismatch == 0 && n_unexpected == 0 && pending_blocks.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
